### hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Each one checks on the rising edge of
// the given clock and is switched off while the active-low reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/cst_pkg.sv
package cst_pkg;

  // Longest lexeme whose length is counted exactly.
  localparam int MAX_LEXEME_DEF = 1024;

  localparam int CH_W   = 8;
  localparam int KIND_W = 4;
  localparam int LINE_W = 20;
  localparam int KW_W   = 4;

  localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);
  localparam logic [LINE_W-1:0] LINE_LAST  = '1;

  // Depth of the token queue in front of the result channel.
  localparam int FIFO_DEPTH = 4;

  // Character codes.
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;

  // Keyword-match progress: characters of "print" or "let" matched so far.
  localparam logic [KW_W-1:0] KW_NONE  = 4'd0;
  localparam logic [KW_W-1:0] KW_P     = 4'd1;
  localparam logic [KW_W-1:0] KW_PR    = 4'd2;
  localparam logic [KW_W-1:0] KW_PRI   = 4'd3;
  localparam logic [KW_W-1:0] KW_PRIN  = 4'd4;
  localparam logic [KW_W-1:0] KW_PRINT = 4'd5;
  localparam logic [KW_W-1:0] KW_L     = 4'd6;
  localparam logic [KW_W-1:0] KW_LE    = 4'd7;
  localparam logic [KW_W-1:0] KW_LET   = 4'd8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLUS    = 4'd0,
    KIND_MINUS   = 4'd1,
    KIND_STAR    = 4'd2,
    KIND_SLASH   = 4'd3,
    KIND_LPAR    = 4'd4,
    KIND_RPAR    = 4'd5,
    KIND_SEMI    = 4'd6,
    KIND_EQUALS  = 4'd7,
    KIND_PERCENT = 4'd8,
    KIND_NUMBER  = 4'd9,
    KIND_IDENT   = 4'd10,
    KIND_PRINT   = 4'd11,
    KIND_LET     = 4'd12,
    KIND_END     = 4'd13,
    KIND_ERROR   = 4'd14
  } tok_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } word_mode_t;

  // Token fields whose widths do not depend on the lexeme limit.
  typedef struct packed {
    tok_kind_t         kind;
    logic [LINE_W-1:0] line;
    logic              too_long;
    logic              last;
  } tok_info_t;

  function automatic logic is_lower(input logic [CH_W-1:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [CH_W-1:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // One-character operators.
  function automatic logic is_op(input logic [CH_W-1:0] c);
    logic r;
    unique case (c)
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h3B, 8'h3D, 8'h25: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic tok_kind_t op_kind(input logic [CH_W-1:0] c);
    tok_kind_t k;
    unique case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h28:   k = KIND_LPAR;
      8'h29:   k = KIND_RPAR;
      8'h3B:   k = KIND_SEMI;
      8'h3D:   k = KIND_EQUALS;
      8'h25:   k = KIND_PERCENT;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Advance the keyword match by one character of the pending word.
  function automatic logic [KW_W-1:0] kw_next(input logic [KW_W-1:0] p,
                                              input logic [CH_W-1:0] c);
    logic [KW_W-1:0] r;
    unique case (p)
      KW_P:    r = (c == 8'h72) ? KW_PR    : KW_NONE;
      KW_PR:   r = (c == 8'h69) ? KW_PRI   : KW_NONE;
      KW_PRI:  r = (c == 8'h6E) ? KW_PRIN  : KW_NONE;
      KW_PRIN: r = (c == 8'h74) ? KW_PRINT : KW_NONE;
      KW_L:    r = (c == 8'h65) ? KW_LE    : KW_NONE;
      KW_LE:   r = (c == 8'h74) ? KW_LET   : KW_NONE;
      default: r = KW_NONE;
    endcase
    return r;
  endfunction

  // Keyword progress after the first character of a word.
  function automatic logic [KW_W-1:0] kw_first(input logic [CH_W-1:0] c);
    logic [KW_W-1:0] r;
    unique case (c)
      8'h70:   r = KW_P;
      8'h6C:   r = KW_L;
      default: r = KW_NONE;
    endcase
    return r;
  endfunction

endpackage

### hdl/cst_ifs.sv
// Character channel: one source byte or an end-of-input mark per beat.
interface cst_char_if
  import cst_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink   (input valid, ch, end_of_input, output ready);
endinterface

// Token channel: one token per beat.
interface cst_tok_if
  import cst_pkg::*;
#(
  parameter int LEN_W = 11
) ();
  logic              valid;
  logic              ready;
  tok_kind_t         token_kind;
  logic [LINE_W-1:0] token_line;
  logic [LEN_W-1:0]  token_length;
  logic              too_long;
  logic              last_of_run;

  modport source (output valid, token_kind, token_line, token_length, too_long,
                  last_of_run, input ready);
  modport sink   (input valid, token_kind, token_line, token_length, too_long,
                  last_of_run, output ready);
endinterface

### hdl/char_stream_tokenizer.sv
// Channel   Dir  Beat contents
// in_chan   in   ch, end_of_input
// out_chan  out  token_kind, token_line, token_length, too_long, last_of_run
//
// A character beat is decoded in the cycle it is accepted and its tokens are
// registered in a four-entry token queue before they appear on out_chan.
// One beat is taken per cycle while the queue has room for two tokens; the queue
// drains one token per cycle with out_chan ready; two-token beats set the pace.
// Reset is synchronous and active low: line 1, no pending word, queue empty.
// A stalled result side fills the queue past two tokens and then holds off in_chan.
`include "assert_macros.svh"

module char_stream_tokenizer
  import cst_pkg::*;
#(
  parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cst_char_if.sink  in_chan,
  cst_tok_if.source out_chan
);

  localparam int LEN_W = $clog2(MAX_LEXEME + 1);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic             accept;
  logic             room2;
  logic [1:0]       push_n;
  tok_info_t        tok0_info, tok1_info;
  logic [LEN_W-1:0] tok0_len, tok1_len;
  logic [CNT_W-1:0] fill;

  // A beat is taken only when both of its possible tokens fit.
  assign in_chan.ready = room2;
  assign accept        = in_chan.valid && room2;

  cst_lexer #(
    .MAX_LEXEME (MAX_LEXEME),
    .LEN_W      (LEN_W)
  ) u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .ch           (in_chan.ch),
    .end_of_input (in_chan.end_of_input),
    .push_n       (push_n),
    .tok0_info    (tok0_info),
    .tok0_len     (tok0_len),
    .tok1_info    (tok1_info),
    .tok1_len     (tok1_len)
  );

  cst_tok_fifo #(
    .LEN_W (LEN_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .tok0_info (tok0_info),
    .tok0_len  (tok0_len),
    .tok1_info (tok1_info),
    .tok1_len  (tok1_len),
    .room2     (room2),
    .fill      (fill),
    .out_chan  (out_chan)
  );

  // Checks on the decode and the token queue.
  `CST_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill <= CNT_W'(FIFO_DEPTH))
  `CST_ASSERT_IMP(a_eoi_emits, clk, rst_n, accept && in_chan.end_of_input, push_n != 2'd0)
  `CST_ASSERT_IMP(a_pair_last, clk, rst_n, push_n == 2'd2, !tok0_info.last && tok1_info.last)
  `CST_ASSERT_NXT(a_push_shows, clk, rst_n, push_n != 2'd0, out_chan.valid)

endmodule

### hdl/cst_lexer.sv
// Lexer state and per-character decode. Produces zero, one or two tokens for
// each accepted beat; the state advances only when a beat is accepted.
module cst_lexer
  import cst_pkg::*;
#(
  parameter int MAX_LEXEME = MAX_LEXEME_DEF,
  parameter int LEN_W      = $clog2(MAX_LEXEME + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [CH_W-1:0]  ch,
  input  logic             end_of_input,
  output logic [1:0]       push_n,
  output tok_info_t        tok0_info,
  output logic [LEN_W-1:0] tok0_len,
  output tok_info_t        tok1_info,
  output logic [LEN_W-1:0] tok1_len
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEXEME);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  word_mode_t        mode_r, mode_nxt;
  logic              lower_r, lower_nxt;
  logic [KW_W-1:0]   kw_r, kw_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  logic              c_lo, c_up, c_dig, c_us, c_word;
  logic              pend;
  logic              fl_vld, sec_vld;
  tok_kind_t         fl_kind, sec_kind;
  logic [LEN_W-1:0]  sec_len;

  // Decode, state update and token selection.
  always_comb begin
    c_lo   = is_lower(ch);
    c_up   = is_upper(ch);
    c_dig  = is_digit(ch);
    c_us   = (ch == CH_UNDER);
    c_word = c_lo || c_up || c_dig || c_us;
    pend   = (mode_r != MODE_IDLE);

    // Kind of the pending word, were it flushed now.
    if (mode_r == MODE_NUM) begin
      fl_kind = KIND_NUMBER;
    end else if (lower_r && !ovf_r && (kw_r == KW_PRINT)) begin
      fl_kind = KIND_PRINT;
    end else if (lower_r && !ovf_r && (kw_r == KW_LET)) begin
      fl_kind = KIND_LET;
    end else begin
      fl_kind = KIND_IDENT;
    end

    mode_nxt  = mode_r;
    lower_nxt = lower_r;
    kw_nxt    = kw_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    line_nxt  = line_r;
    fl_vld    = 1'b0;
    sec_vld   = 1'b0;
    sec_kind  = KIND_ERROR;
    sec_len   = LEN_ONE;

    if (end_of_input) begin
      fl_vld    = pend;
      sec_vld   = 1'b1;
      sec_kind  = KIND_END;
      sec_len   = '0;
      mode_nxt  = MODE_IDLE;
      lower_nxt = 1'b1;
      kw_nxt    = KW_NONE;
      cnt_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else if (((mode_r == MODE_NUM) && c_dig) || ((mode_r == MODE_WORD) && c_word)) begin
      // The pending lexeme grows by one character.
      if (cnt_r < LEN_MAX) begin
        cnt_nxt = cnt_r + LEN_ONE;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (mode_r == MODE_WORD) begin
        if (!c_lo) begin
          lower_nxt = 1'b0;
        end
        kw_nxt = kw_next(kw_r, ch);
      end
    end else begin
      // Any pending lexeme ends here.
      fl_vld    = pend;
      mode_nxt  = MODE_IDLE;
      lower_nxt = 1'b1;
      kw_nxt    = KW_NONE;
      cnt_nxt   = '0;
      ovf_nxt   = 1'b0;
      priority if (ch == CH_LF) begin
        if (line_r != LINE_LAST) begin
          line_nxt = line_r + LINE_FIRST;
        end
      end else if ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR)) begin
        mode_nxt = MODE_IDLE;
      end else if (is_op(ch)) begin
        sec_vld  = 1'b1;
        sec_kind = op_kind(ch);
      end else if (c_dig) begin
        mode_nxt = MODE_NUM;
        cnt_nxt  = LEN_ONE;
      end else if (c_lo || c_up || c_us) begin
        mode_nxt  = MODE_WORD;
        cnt_nxt   = LEN_ONE;
        lower_nxt = c_lo;
        kw_nxt    = kw_first(ch);
      end else begin
        sec_vld  = 1'b1;
        sec_kind = KIND_ERROR;
      end
    end

    // Pack the tokens into the lower slots, flushed word first.
    tok0_info.line     = line_r;
    tok1_info.line     = line_r;
    tok1_info.kind     = sec_kind;
    tok1_info.too_long = 1'b0;
    tok1_info.last     = 1'b1;
    tok1_len           = sec_len;
    if (fl_vld) begin
      tok0_info.kind     = fl_kind;
      tok0_info.too_long = ovf_r;
      tok0_info.last     = !sec_vld;
      tok0_len           = cnt_r;
      push_n             = sec_vld ? 2'd2 : 2'd1;
    end else begin
      tok0_info.kind     = sec_kind;
      tok0_info.too_long = 1'b0;
      tok0_info.last     = 1'b1;
      tok0_len           = sec_len;
      push_n             = sec_vld ? 2'd1 : 2'd0;
    end
    if (!accept) begin
      push_n = 2'd0;
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      lower_r <= 1'b1;
      kw_r    <= KW_NONE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      line_r  <= LINE_FIRST;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      lower_r <= lower_nxt;
      kw_r    <= kw_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

### hdl/cst_tok_fifo.sv
// Small token queue: takes up to two tokens per cycle, gives one per beat.
module cst_tok_fifo
  import cst_pkg::*;
#(
  parameter int LEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  tok_info_t        tok0_info,
  input  logic [LEN_W-1:0] tok0_len,
  input  tok_info_t        tok1_info,
  input  logic [LEN_W-1:0] tok1_len,
  output logic             room2,
  output logic [$clog2(FIFO_DEPTH+1)-1:0] fill,
  cst_tok_if.source        out_chan
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  tok_info_t        info_q [FIFO_DEPTH];
  logic [LEN_W-1:0] len_q  [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_p1;
  logic             pop;

  // Pointer and fill arithmetic.
  always_comb begin
    pop     = out_chan.valid && out_chan.ready;
    wr_p1   = wr_r + PTR_W'(1);
    wr_nxt  = wr_r + PTR_W'(push_n);
    rd_nxt  = pop ? (rd_r + PTR_W'(1)) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  assign room2 = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign fill  = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      info_q[wr_r] <= tok0_info;
      len_q[wr_r]  <= tok0_len;
    end
    if (push_n == 2'd2) begin
      info_q[wr_p1] <= tok1_info;
      len_q[wr_p1]  <= tok1_len;
    end
  end

  // Head of the queue drives the result beat.
  assign out_chan.valid        = (cnt_r != '0);
  assign out_chan.token_kind   = info_q[rd_r].kind;
  assign out_chan.token_line   = info_q[rd_r].line;
  assign out_chan.too_long     = info_q[rd_r].too_long;
  assign out_chan.last_of_run  = info_q[rd_r].last;
  assign out_chan.token_length = len_q[rd_r];

endmodule
